>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PRQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("prq assertion failed");

// Condition that must never hold outside reset.
`define PRQ_NEVER(lbl, cond) `PRQ_ASSERT(lbl, !(cond))

`endif

>>> rtl/core/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Types, codes and constants of the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

  // Default sizes.
  localparam int unsigned NUM_SLOTS_DEF  = 32;
  localparam int unsigned NUM_LEVELS_DEF = 4;

  // Fixed field widths.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned TID_W  = 5;
  localparam int unsigned PRI_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned RT_W   = 5;
  localparam int unsigned FC_W   = 6;
  localparam int unsigned IDLE_W = 32;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_KERNEL = 1'b0;
  localparam logic        REG_IDLE   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHED  = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_TERM   = 3'd2,
    CMD_CHANGE = 3'd3,
    CMD_REAP   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_BAD    = 2'd2,
    STAT_NOTQ   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_EXITING = 2'd3
  } slot_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SEL,
    S_FIND,
    S_PUSH,
    S_RUN,
    S_CRD,
    S_CCHK,
    S_CMK,
    S_TRD,
    S_TCHK,
    S_TFIND,
    S_CPUSH,
    S_RRD,
    S_RCHK,
    S_RESP
  } sched_state_e;

  // Operation broadcast along the ready chain.
  typedef struct packed {
    logic init;
    logic remove;
    logic push;
  } chain_op_t;

endpackage

`default_nettype wire

>>> rtl/core/priority_ready_queue_scheduler.sv
// The chain scan reads one chain cell a cycle; the free-slot and reap walks read
// each slot over the slot table's read port and then check it.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset, and any configuration write, restore the initial task set at once.
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Multilevel ready-queue task scheduler with a chain of queue cells, a slot
// table and a command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module priority_ready_queue_scheduler #(
  parameter int unsigned NUM_SLOTS  = prq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [prq_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [prq_pkg::PDATA_W-1:0]   pwdata,
  output logic      [prq_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [prq_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [prq_pkg::TID_W-1:0]     task_id_i,
  input  wire logic [prq_pkg::PRI_W-1:0]     new_priority_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [prq_pkg::STAT_W-1:0]    status_o,
  output logic      [prq_pkg::RT_W-1:0]      result_task_o,
  output logic                               switched_o,
  output logic      [prq_pkg::FC_W-1:0]      freed_count_o,
  output logic      [prq_pkg::IDLE_W-1:0]    idle_runs_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned LW = $clog2(NUM_LEVELS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned DW = SW + LW;
  localparam int unsigned EW = 2 + LW;
  localparam int unsigned KL_RST = 0;
  localparam int unsigned IL_RST = (NUM_LEVELS > 3) ? 3 : NUM_LEVELS - 1;

  function automatic logic [LW-1:0] clamp_lvl(input logic [prq_pkg::PRI_W-1:0] p);
    logic [LW-1:0] r;
    if (32'(p) >= NUM_LEVELS) begin
      r = LW'(NUM_LEVELS - 1);
    end else begin
      r = LW'(p);
    end
    return r;
  endfunction

  prq_pkg::sched_state_e state_q, state_d;

  logic [prq_pkg::PRI_W-1:0]  kp_q, kp_d, ip_q, ip_d;
  logic [prq_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [prq_pkg::TID_W-1:0]  tid_q, tid_d;
  logic [prq_pkg::PRI_W-1:0]  pri_q, pri_d;
  logic [LW-1:0]              lvl_q, lvl_d, key_q, key_d;
  logic                       pass_q, pass_d;
  logic [CW-1:0]              k_q, k_d, addr_q, addr_d;
  logic [SW-1:0]              next_q, next_d;
  prq_pkg::status_e           st_q, st_d;
  logic [prq_pkg::RT_W-1:0]   rt_q, rt_d;
  logic                       sw_q, sw_d;
  logic [prq_pkg::FC_W-1:0]   fc_q, fc_d;
  logic [CW-1:0]              len_q [NUM_LEVELS];
  logic [CW-1:0]              len_d [NUM_LEVELS];
  logic [CW-1:0]              rc_q  [NUM_LEVELS];
  logic [CW-1:0]              rc_d  [NUM_LEVELS];
  logic [SW-1:0]              run_q, run_d;
  logic [LW-1:0]              rprio_q, rprio_d;
  logic                       rexit_q, rexit_d;
  logic [CW-1:0]              exit_len_q, exit_len_d;
  logic [prq_pkg::IDLE_W-1:0] idle_q, idle_d;

  logic                       out_valid_q;
  logic [prq_pkg::STAT_W-1:0] out_st_q;
  logic [prq_pkg::RT_W-1:0]   out_rt_q;
  logic                       out_sw_q;
  logic [prq_pkg::FC_W-1:0]   out_fc_q;
  logic [prq_pkg::IDLE_W-1:0] out_idle_q;
  logic                       out_load;

  logic                       cfg_we;
  logic [LW-1:0]              kl_n, il_n, kl_c, il_c;
  logic [SW-1:0]              tid_s;
  logic [LW-1:0]              pri_l;
  logic                       tid_bad, pri_bad;
  logic                       need;

  prq_pkg::chain_op_t         chn_op;
  logic [SW-1:0]              chn_rm_pos;
  logic [DW-1:0]              chn_push;
  logic [DW-1:0]              chn_rd;
  logic [CW-1:0]              chn_cnt;
  logic [SW-1:0]              chn_slot;
  logic [LW-1:0]              chn_lvl;

  logic [SW-1:0]              tbl_ra;
  logic [EW-1:0]              tbl_rd;
  logic                       tbl_we;
  logic [SW-1:0]              tbl_wa;
  logic [EW-1:0]              tbl_wd;
  prq_pkg::slot_state_e       tbl_state;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = {{(prq_pkg::PDATA_W - prq_pkg::PRI_W){1'b0}},
                   (paddr[2] == prq_pkg::REG_IDLE) ? ip_q : kp_q};
  assign kl_n = clamp_lvl(kp_d);
  assign il_n = clamp_lvl(ip_d);
  assign kl_c = clamp_lvl(kp_q);
  assign il_c = clamp_lvl(ip_q);

  // Decoded fields of the current item.
  assign tid_s     = SW'(tid_q);
  assign pri_l     = LW'(pri_q);
  assign tid_bad   = 32'(tid_q) >= NUM_SLOTS;
  assign pri_bad   = 32'(pri_q) >= NUM_LEVELS;
  assign need      = (rprio_q == pri_l);
  assign chn_slot  = chn_rd[DW-1 -: SW];
  assign chn_lvl   = chn_rd[LW-1:0];
  assign tbl_state = prq_pkg::slot_state_e'(tbl_rd[EW-1 -: 2]);

  assign in_ready_o = (state_q == prq_pkg::S_IDLE);
  assign out_load   = (state_q == prq_pkg::S_RESP) && (!out_valid_q || out_ready_i);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d    = state_q;
    kp_d       = kp_q;
    ip_d       = ip_q;
    cmd_d      = cmd_q;
    tid_d      = tid_q;
    pri_d      = pri_q;
    lvl_d      = lvl_q;
    key_d      = key_q;
    pass_d     = pass_q;
    k_d        = k_q;
    addr_d     = addr_q;
    next_d     = next_q;
    st_d       = st_q;
    rt_d       = rt_q;
    sw_d       = sw_q;
    fc_d       = fc_q;
    len_d      = len_q;
    rc_d       = rc_q;
    run_d      = run_q;
    rprio_d    = rprio_q;
    rexit_d    = rexit_q;
    exit_len_d = exit_len_q;
    idle_d     = idle_q;
    chn_op     = '0;
    chn_rm_pos = k_q[SW-1:0];
    chn_push   = {run_q, rprio_q};
    tbl_ra     = addr_q[SW-1:0];
    tbl_we     = 1'b0;
    tbl_wa     = run_q;
    tbl_wd     = {prq_pkg::SLOT_RUNNING, rprio_q};

    case (state_q)
      prq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          tid_d   = task_id_i;
          pri_d   = new_priority_i;
          st_d    = prq_pkg::STAT_OK;
          rt_d    = '0;
          sw_d    = 1'b0;
          fc_d    = '0;
          state_d = prq_pkg::S_DISP;
        end
      end

      prq_pkg::S_DISP: begin
        case (cmd_q)
          prq_pkg::CMD_SCHED: begin
            lvl_d   = '0;
            pass_d  = 1'b0;
            state_d = prq_pkg::S_SEL;
          end
          prq_pkg::CMD_CREATE: begin
            if (pri_bad) begin
              st_d    = prq_pkg::STAT_BAD;
              state_d = prq_pkg::S_RESP;
            end else begin
              addr_d  = CW'(2);
              state_d = prq_pkg::S_CRD;
            end
          end
          prq_pkg::CMD_TERM: begin
            if (tid_bad || tid_q < prq_pkg::TID_W'(2)) begin
              st_d    = prq_pkg::STAT_BAD;
              state_d = prq_pkg::S_RESP;
            end else if (tid_s == run_q) begin
              rexit_d = 1'b1;
              tbl_we  = 1'b1;
              tbl_wd  = {prq_pkg::SLOT_EXITING, rprio_q};
              state_d = prq_pkg::S_RESP;
            end else begin
              state_d = prq_pkg::S_TRD;
            end
          end
          prq_pkg::CMD_CHANGE: begin
            if (tid_bad || pri_bad) begin
              st_d    = prq_pkg::STAT_BAD;
              state_d = prq_pkg::S_RESP;
            end else if (tid_s == run_q) begin
              rprio_d = pri_l;
              tbl_we  = 1'b1;
              tbl_wd  = {(rexit_q ? prq_pkg::SLOT_EXITING : prq_pkg::SLOT_RUNNING), pri_l};
              state_d = prq_pkg::S_RESP;
            end else begin
              state_d = prq_pkg::S_TRD;
            end
          end
          prq_pkg::CMD_REAP: begin
            fc_d       = prq_pkg::FC_W'(exit_len_q);
            exit_len_d = '0;
            addr_d     = '0;
            state_d    = prq_pkg::S_RRD;
          end
          default: begin
            st_d    = prq_pkg::STAT_BAD;
            state_d = prq_pkg::S_RESP;
          end
        endcase
      end

      // Level selection, one level a cycle, at most two passes.
      prq_pkg::S_SEL: begin
        if (rc_q[lvl_q] < len_q[lvl_q]) begin
          rc_d[lvl_q] = rc_q[lvl_q] + CW'(1);
          key_d       = lvl_q;
          k_d         = '0;
          state_d     = prq_pkg::S_FIND;
        end else begin
          rc_d[lvl_q] = '0;
          if (lvl_q == LW'(NUM_LEVELS - 1)) begin
            if (pass_q) begin
              rt_d    = prq_pkg::RT_W'(run_q);
              state_d = prq_pkg::S_RESP;
            end else begin
              pass_d = 1'b1;
              lvl_d  = '0;
            end
          end else begin
            lvl_d = lvl_q + LW'(1);
          end
        end
      end

      // Walk the chain for the front entry of the chosen level.
      prq_pkg::S_FIND: begin
        if (chn_lvl == key_q) begin
          chn_op.remove = 1'b1;
          len_d[key_q]  = len_q[key_q] - CW'(1);
          next_d        = chn_slot;
          state_d       = prq_pkg::S_PUSH;
        end else begin
          k_d = k_q + CW'(1);
        end
      end

      // Retire the old task.
      prq_pkg::S_PUSH: begin
        if (rexit_q) begin
          exit_len_d = exit_len_q + CW'(1);
        end else begin
          chn_op.push    = 1'b1;
          len_d[rprio_q] = len_q[rprio_q] + CW'(1);
          tbl_we         = 1'b1;
          tbl_wd         = {prq_pkg::SLOT_READY, rprio_q};
        end
        state_d = prq_pkg::S_RUN;
      end

      // Switch in the new task.
      prq_pkg::S_RUN: begin
        run_d   = next_q;
        rprio_d = key_q;
        rexit_d = 1'b0;
        tbl_we  = 1'b1;
        tbl_wa  = next_q;
        tbl_wd  = {prq_pkg::SLOT_RUNNING, key_q};
        if (next_q == SW'(1)) begin
          idle_d = idle_q + prq_pkg::IDLE_W'(1);
        end
        sw_d    = 1'b1;
        rt_d    = prq_pkg::RT_W'(next_q);
        state_d = prq_pkg::S_RESP;
      end

      // Free-slot search: read each slot, then check it.
      prq_pkg::S_CRD: begin
        state_d = prq_pkg::S_CCHK;
      end

      prq_pkg::S_CCHK: begin
        if (tbl_state == prq_pkg::SLOT_FREE) begin
          state_d = prq_pkg::S_CMK;
        end else if (addr_q == CW'(NUM_SLOTS - 1)) begin
          st_d    = prq_pkg::STAT_NOFREE;
          state_d = prq_pkg::S_RESP;
        end else begin
          addr_d  = addr_q + CW'(1);
          state_d = prq_pkg::S_CRD;
        end
      end

      prq_pkg::S_CMK: begin
        if (len_q[pri_l] >= CW'(NUM_SLOTS) - CW'(need)) begin
          st_d = prq_pkg::STAT_NOFREE;
        end else begin
          chn_op.push  = 1'b1;
          chn_push     = {addr_q[SW-1:0], pri_l};
          len_d[pri_l] = len_q[pri_l] + CW'(1);
          tbl_we       = 1'b1;
          tbl_wa       = addr_q[SW-1:0];
          tbl_wd       = {prq_pkg::SLOT_READY, pri_l};
          rt_d         = prq_pkg::RT_W'(addr_q);
        end
        state_d = prq_pkg::S_RESP;
      end

      // Terminate and change of a queued task.
      prq_pkg::S_TRD: begin
        tbl_ra  = tid_s;
        state_d = prq_pkg::S_TCHK;
      end

      prq_pkg::S_TCHK: begin
        if (tbl_state != prq_pkg::SLOT_READY) begin
          st_d    = prq_pkg::STAT_NOTQ;
          state_d = prq_pkg::S_RESP;
        end else begin
          k_d     = '0;
          state_d = prq_pkg::S_TFIND;
        end
      end

      prq_pkg::S_TFIND: begin
        if (k_q == chn_cnt) begin
          st_d    = prq_pkg::STAT_NOTQ;
          state_d = prq_pkg::S_RESP;
        end else if (chn_slot == tid_s) begin
          chn_op.remove  = 1'b1;
          len_d[chn_lvl] = len_q[chn_lvl] - CW'(1);
          if (cmd_q == prq_pkg::CMD_TERM) begin
            tbl_we     = 1'b1;
            tbl_wa     = tid_s;
            tbl_wd     = {prq_pkg::SLOT_EXITING, chn_lvl};
            exit_len_d = exit_len_q + CW'(1);
            state_d    = prq_pkg::S_RESP;
          end else begin
            state_d = prq_pkg::S_CPUSH;
          end
        end else begin
          k_d = k_q + CW'(1);
        end
      end

      prq_pkg::S_CPUSH: begin
        chn_op.push  = 1'b1;
        chn_push     = {tid_s, pri_l};
        len_d[pri_l] = len_q[pri_l] + CW'(1);
        tbl_we       = 1'b1;
        tbl_wa       = tid_s;
        tbl_wd       = {prq_pkg::SLOT_READY, pri_l};
        state_d      = prq_pkg::S_RESP;
      end

      // Reap sweep: free every exiting slot that is not running.
      prq_pkg::S_RRD: begin
        state_d = prq_pkg::S_RCHK;
      end

      prq_pkg::S_RCHK: begin
        if (tbl_state == prq_pkg::SLOT_EXITING && addr_q[SW-1:0] != run_q) begin
          tbl_we = 1'b1;
          tbl_wa = addr_q[SW-1:0];
          tbl_wd = {prq_pkg::SLOT_FREE, tbl_rd[LW-1:0]};
        end
        if (addr_q == CW'(NUM_SLOTS - 1)) begin
          state_d = prq_pkg::S_RESP;
        end else begin
          addr_d  = addr_q + CW'(1);
          state_d = prq_pkg::S_RRD;
        end
      end

      prq_pkg::S_RESP: begin
        if (out_load) begin
          state_d = prq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = prq_pkg::S_IDLE;
      end
    endcase

    // A configuration write reinitializes the task set.
    if (cfg_we) begin
      if (paddr[2] == prq_pkg::REG_IDLE) begin
        ip_d = pwdata[prq_pkg::PRI_W-1:0];
      end else begin
        kp_d = pwdata[prq_pkg::PRI_W-1:0];
      end
      chn_op      = '0;
      chn_op.init = 1'b1;
      tbl_we      = 1'b0;
      for (int j = 0; j < NUM_LEVELS; j++) begin
        len_d[j] = (LW'(j) == il_n) ? CW'(1) : CW'(0);
        rc_d[j]  = (LW'(j) == kl_n && kl_n != il_n) ? CW'(1) : CW'(0);
      end
      run_d      = '0;
      rprio_d    = kl_n;
      rexit_d    = 1'b0;
      exit_len_d = '0;
      idle_d     = '0;
    end
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= prq_pkg::S_IDLE;
      kp_q       <= prq_pkg::PRI_W'(0);
      ip_q       <= prq_pkg::PRI_W'(3);
      for (int j = 0; j < NUM_LEVELS; j++) begin
        len_q[j] <= (j == IL_RST) ? CW'(1) : CW'(0);
        rc_q[j]  <= (j == KL_RST && KL_RST != IL_RST) ? CW'(1) : CW'(0);
      end
      run_q      <= '0;
      rprio_q    <= LW'(KL_RST);
      rexit_q    <= 1'b0;
      exit_len_q <= '0;
      idle_q     <= '0;
    end else begin
      state_q    <= state_d;
      kp_q       <= kp_d;
      ip_q       <= ip_d;
      len_q      <= len_d;
      rc_q       <= rc_d;
      run_q      <= run_d;
      rprio_q    <= rprio_d;
      rexit_q    <= rexit_d;
      exit_len_q <= exit_len_d;
      idle_q     <= idle_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    tid_q  <= tid_d;
    pri_q  <= pri_d;
    lvl_q  <= lvl_d;
    key_q  <= key_d;
    pass_q <= pass_d;
    k_q    <= k_d;
    addr_q <= addr_d;
    next_q <= next_d;
    st_q   <= st_d;
    rt_q   <= rt_d;
    sw_q   <= sw_d;
    fc_q   <= fc_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q   <= st_q;
      out_rt_q   <= rt_q;
      out_sw_q   <= sw_q;
      out_fc_q   <= fc_q;
      out_idle_q <= idle_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign result_task_o = out_rt_q;
  assign switched_o    = out_sw_q;
  assign freed_count_o = out_fc_q;
  assign idle_runs_o   = out_idle_q;

  // Ready chain.
  prq_chain #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS),
    .INIT_LVL   (IL_RST)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (chn_op),
    .rm_pos_i    (chn_rm_pos),
    .push_data_i (chn_push),
    .init_data_i ({SW'(1), il_n}),
    .rd_idx_i    (k_q[SW-1:0]),
    .rd_data_o   (chn_rd),
    .cnt_o       (chn_cnt)
  );

  // Slot table.
  prq_slot_table #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_we),
    .kl_i      (kl_c),
    .il_i      (il_c),
    .rd_addr_i (tbl_ra),
    .rd_data_o (tbl_rd),
    .wr_en_i   (tbl_we),
    .wr_addr_i (tbl_wa),
    .wr_data_i (tbl_wd)
  );

  // Checks on chain occupancy and result timing.
  `PRQ_ASSERT(a_push_room, chn_op.push |-> chn_cnt < CW'(NUM_SLOTS))
  `PRQ_ASSERT(a_remove_nonempty, chn_op.remove |-> chn_cnt != CW'(0))
  `PRQ_ASSERT(a_out_from_resp, $rose(out_valid_q) |-> $past(state_q == prq_pkg::S_RESP))
  `PRQ_NEVER(a_exit_overflow, exit_len_q > CW'(NUM_SLOTS))

endmodule

`default_nettype wire

>>> rtl/core/prq_cell.sv
// ----------------------------------------------------------------------------
// prq_cell
// One entry of the ready chain: holds a slot and its level, takes its upper
// neighbor's entry on a removal and the pushed entry when it is the first free cell.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_cell #(
  parameter int unsigned     DW      = 7,
  parameter logic [DW-1:0]   RST_VAL = '0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_en_i,
  input  wire logic          load_en_i,
  input  wire logic          init_en_i,
  input  wire logic [DW-1:0] next_i,
  input  wire logic [DW-1:0] load_i,
  input  wire logic [DW-1:0] init_i,
  output logic      [DW-1:0] data_o
);

  logic [DW-1:0] data_q;

  // Init wins, then the shift toward the head, then the tail load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= RST_VAL;
    end else if (init_en_i) begin
      data_q <= init_i;
    end else if (shift_en_i) begin
      data_q <= next_i;
    end else if (load_en_i) begin
      data_q <= load_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/core/prq_chain.sv
// ----------------------------------------------------------------------------
// prq_chain
// Row of cells holding every ready task in arrival order. Each level's FIFO
// is the subsequence of cells carrying that level.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_chain #(
  parameter int unsigned NUM_SLOTS  = prq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
  parameter int unsigned INIT_LVL   = 3,
  localparam int unsigned SW = $clog2(NUM_SLOTS),
  localparam int unsigned LW = $clog2(NUM_LEVELS),
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1),
  localparam int unsigned DW = SW + LW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prq_pkg::chain_op_t  op_i,
  input  wire logic [SW-1:0]       rm_pos_i,
  input  wire logic [DW-1:0]       push_data_i,
  input  wire logic [DW-1:0]       init_data_i,
  input  wire logic [SW-1:0]       rd_idx_i,
  output logic      [DW-1:0]       rd_data_o,
  output logic      [CW-1:0]       cnt_o
);

  logic [CW-1:0] cnt_q;
  logic [DW-1:0] cell_d [NUM_SLOTS];

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(1);
    end else if (op_i.init) begin
      cnt_q <= CW'(1);
    end else if (op_i.remove) begin
      cnt_q <= cnt_q - CW'(1);
    end else if (op_i.push) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // The cells, each fed by its upper neighbor.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    logic [DW-1:0] next;
    logic [DW-1:0] init;
    if (g == NUM_SLOTS - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid
      assign next = cell_d[g+1];
    end
    if (g == 0) begin : g_head
      assign init = init_data_i;
    end else begin : g_body
      assign init = '0;
    end
    prq_cell #(
      .DW      (DW),
      .RST_VAL ((g == 0) ? {SW'(1), LW'(INIT_LVL)} : DW'(0))
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (op_i.remove && (SW'(g) >= rm_pos_i)),
      .load_en_i  (op_i.push && (CW'(g) == cnt_q)),
      .init_en_i  (op_i.init),
      .next_i     (next),
      .load_i     (push_data_i),
      .init_i     (init),
      .data_o     (cell_d[g])
    );
  end

  // Scan read port.
  assign rd_data_o = cell_d[rd_idx_i];
  assign cnt_o     = cnt_q;

endmodule

`default_nettype wire

>>> rtl/core/prq_slot_table.sv
// ----------------------------------------------------------------------------
// prq_slot_table
// Per-slot state and priority in a memory with one read and one write port and
// valid bits; an entry not yet written reads as its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_slot_table #(
  parameter int unsigned NUM_SLOTS  = prq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
  localparam int unsigned SW = $clog2(NUM_SLOTS),
  localparam int unsigned LW = $clog2(NUM_LEVELS),
  localparam int unsigned EW = 2 + LW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire logic [LW-1:0] kl_i,
  input  wire logic [LW-1:0] il_i,
  input  wire logic [SW-1:0] rd_addr_i,
  output logic      [EW-1:0] rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [SW-1:0] wr_addr_i,
  input  wire logic [EW-1:0] wr_data_i
);

  logic [EW-1:0]        mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;
  logic [EW-1:0]        dflt;
  logic [EW-1:0]        rd_q;

  // Reset value of the addressed entry.
  always_comb begin
    if (rd_addr_i == SW'(0)) begin
      dflt = {prq_pkg::SLOT_RUNNING, kl_i};
    end else if (rd_addr_i == SW'(1)) begin
      dflt = {prq_pkg::SLOT_READY, il_i};
    end else begin
      dflt = {prq_pkg::SLOT_FREE, LW'(0)};
    end
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Valid bits, cleared at once on reset and on reinitialization.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : dflt;
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire
